// File: hw/rtl/mqttrx_pkg.sv
// Shared types and constants of the MQTT receive packet parser.
`timescale 1ns / 1ps
`default_nettype none

package mqttrx_pkg;

  localparam int LEN_W   = 28;  // remaining length, four base-128 digits
  localparam int TOPIC_W = 16;  // PUBLISH topic length field
  localparam int MAXB_W  = 29;  // max_packet_bytes register
  localparam int CNT_W   = 3;   // length byte counter, holds 0..4

  // Control packet types from the header's upper nibble
  localparam logic [3:0] PKT_CONNACK  = 4'd2;
  localparam logic [3:0] PKT_PUBLISH  = 4'd3;
  localparam logic [3:0] PKT_PUBACK   = 4'd4;
  localparam logic [3:0] PKT_SUBACK   = 4'd9;
  localparam logic [3:0] PKT_UNSUBACK = 4'd11;
  localparam logic [3:0] PKT_PINGRESP = 4'd13;

  typedef enum logic [2:0] {
    KIND_HEADER,
    KIND_LENGTH,
    KIND_TOPIC_LEN,
    KIND_TOPIC,
    KIND_PACKET_ID,
    KIND_PAYLOAD,
    KIND_OTHER
  } byte_kind_t;

  typedef enum logic [2:0] {
    VERDICT_OK,
    VERDICT_BAD_LENGTH,
    VERDICT_EMPTY_TOPIC,
    VERDICT_TOPIC_OVERRUN,
    VERDICT_REFUSED,
    VERDICT_UNSUPPORTED,
    VERDICT_MALFORMED,
    VERDICT_OVERSIZE
  } verdict_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_CONNECT,
    UPD_IDLE
  } state_update_t;

  // Packet facts needed to judge a packet on its last byte
  typedef struct packed {
    logic [3:0]         pkt_type;
    logic [1:0]         qos;
    logic [LEN_W-1:0]   rem_len;
    logic [TOPIC_W-1:0] topic_len;
    logic [7:0]         return_code;
    logic               oversize;
  } finish_in_t;

  // Verdict and client effects of a completed packet
  typedef struct packed {
    verdict_t      verdict;
    state_update_t update;
    logic          ping_clear;
    logic          activity;
  } effects_t;

endpackage

`default_nettype wire

// File: hw/rtl/mqttrx_verdict.sv
// Per-type length rules and client effects applied on a packet's last byte.
`timescale 1ns / 1ps
`default_nettype none

module mqttrx_verdict (
  input  mqttrx_pkg::finish_in_t fin,
  output mqttrx_pkg::effects_t   eff
);

  logic [mqttrx_pkg::LEN_W-1:0] topic_end;
  logic [mqttrx_pkg::LEN_W-1:0] id_end;

  // Body offsets just past the topic and just past the packet id
  assign topic_end = {{(mqttrx_pkg::LEN_W-mqttrx_pkg::TOPIC_W){1'b0}}, fin.topic_len}
                     + mqttrx_pkg::LEN_W'(2);
  assign id_end    = {{(mqttrx_pkg::LEN_W-mqttrx_pkg::TOPIC_W){1'b0}}, fin.topic_len}
                     + mqttrx_pkg::LEN_W'(4);

  always_comb begin
    eff.verdict    = mqttrx_pkg::VERDICT_OK;
    eff.update     = mqttrx_pkg::UPD_NONE;
    eff.ping_clear = 1'b0;
    eff.activity   = 1'b0;
    if (fin.oversize) begin
      eff.verdict = mqttrx_pkg::VERDICT_OVERSIZE;
    end else begin
      unique case (fin.pkt_type)
        mqttrx_pkg::PKT_CONNACK: begin
          if (fin.rem_len < mqttrx_pkg::LEN_W'(2)) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else if (fin.return_code == 8'd0) begin
            eff.update   = mqttrx_pkg::UPD_CONNECT;
            eff.activity = 1'b1;
          end else begin
            eff.verdict = mqttrx_pkg::VERDICT_REFUSED;
            eff.update  = mqttrx_pkg::UPD_IDLE;
          end
        end
        mqttrx_pkg::PKT_PUBLISH: begin
          if (fin.rem_len < mqttrx_pkg::LEN_W'(2)) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else if (fin.topic_len == '0) begin
            eff.verdict = mqttrx_pkg::VERDICT_EMPTY_TOPIC;
          end else if (topic_end > fin.rem_len) begin
            eff.verdict = mqttrx_pkg::VERDICT_TOPIC_OVERRUN;
          end else if (fin.qos != 2'd0 && id_end > fin.rem_len) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end
        end
        mqttrx_pkg::PKT_PUBACK: begin
          if (fin.rem_len < mqttrx_pkg::LEN_W'(2)) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            eff.update   = mqttrx_pkg::UPD_CONNECT;
            eff.activity = 1'b1;
          end
        end
        mqttrx_pkg::PKT_SUBACK: begin
          if (fin.rem_len < mqttrx_pkg::LEN_W'(3)) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            eff.update   = mqttrx_pkg::UPD_CONNECT;
            eff.activity = 1'b1;
          end
        end
        mqttrx_pkg::PKT_UNSUBACK: begin
          eff.verdict = mqttrx_pkg::VERDICT_OK;
        end
        mqttrx_pkg::PKT_PINGRESP: begin
          if (fin.rem_len != '0) begin
            eff.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            eff.ping_clear = 1'b1;
            eff.activity   = 1'b1;
          end
        end
        default: begin
          eff.verdict = mqttrx_pkg::VERDICT_UNSUPPORTED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mqtt_receive_packet_parser_top.sv
// Top level of the MQTT receive packet parser: byte stream in, tagged bytes out.
`timescale 1ns / 1ps
`default_nettype none

// Parses the MQTT 3.1.1 packets arriving from a broker connection, one byte
// per transaction on the slave stream. Each byte comes back out on the master
// stream tagged with what it is (header, length, topic length, topic, packet
// id, payload, other body) in tuser, together with the packet type and the
// PUBLISH QoS. The byte that completes a packet carries tlast plus a verdict
// and the client effects: go connected, go idle, clear ping pending, refresh
// keep-alive activity. Topic and payload bytes go out before the verdict is
// known, so discard them downstream when the packet's verdict is not ok.
// A fifth length byte ends the packet as malformed; a packet larger than
// cfg_wdata (max_packet_bytes, reset 1024) is consumed to its end and flagged
// oversize. Throughput is one byte per clock while m_axis_tready keeps the
// result register draining; each byte passes through the input register and
// then through the parse logic into the result register, and the running length
// and body counters close their loop within that parse step. Write the register only while idle.
module mqtt_receive_packet_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: max_packet_bytes
  input  wire logic        cfg_wen,
  input  wire logic [28:0] cfg_wdata,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // tagged bytes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [11:8] packet_kind,
                                           // [13:12] publish_qos, [16:14] verdict,
                                           // [18:17] state_update, [19] ping_clear,
                                           // [20] activity, [23:21] zero
  output logic             m_axis_tlast,   // packet_end
  output logic [2:0]       m_axis_tuser    // [2:0] byte_kind
);

  localparam int LEN_W   = mqttrx_pkg::LEN_W;
  localparam int TOPIC_W = mqttrx_pkg::TOPIC_W;
  localparam int MAXB_W  = mqttrx_pkg::MAXB_W;
  localparam int CNT_W   = mqttrx_pkg::CNT_W;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  // Configuration
  logic [MAXB_W-1:0] max_bytes;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  // Parse state
  phase_t             phase, phase_next;
  logic [7:0]         header_byte, header_next;
  logic [LEN_W-1:0]   remaining_len, rl_next;
  logic [CNT_W-1:0]   len_count, cnt_next;
  logic [LEN_W-1:0]   body_count, body_next;
  logic [TOPIC_W-1:0] topic_len, tl_next;
  logic [7:0]         return_code, rc_next;
  logic               oversize, ovs_next;

  // Result register
  logic                      out_valid;
  mqttrx_pkg::byte_kind_t    out_kind;
  logic [7:0]                out_byte;
  logic                      out_end;
  logic [3:0]                out_pkt;
  logic [1:0]                out_qos;
  mqttrx_pkg::verdict_t      out_verdict;
  mqttrx_pkg::state_update_t out_update;
  logic                      out_ping;
  logic                      out_activity;

  // Parse results for the byte in the input register
  mqttrx_pkg::byte_kind_t    res_kind;
  logic                      res_end;
  logic [1:0]                res_qos;
  mqttrx_pkg::verdict_t      res_verdict;
  mqttrx_pkg::state_update_t res_update;
  logic                      res_ping;
  logic                      res_activity;
  logic                      do_finish;
  logic                      malformed;
  logic [LEN_W-1:0]          len_add;
  logic [MAXB_W-1:0]         total_bytes;
  logic [LEN_W-1:0]          topic_end;
  logic [LEN_W-1:0]          id_end;
  mqttrx_pkg::byte_kind_t    body_kind;

  mqttrx_pkg::finish_in_t fin;
  mqttrx_pkg::effects_t   eff;

  // Move a byte from the input register to the result register whenever the
  // result register is empty or being drained this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Place this length digit at its base-128 position
  always_comb begin
    case (len_count[1:0])
      2'd0:    len_add = {21'd0, in_byte[6:0]};
      2'd1:    len_add = {14'd0, in_byte[6:0], 7'd0};
      2'd2:    len_add = {7'd0, in_byte[6:0], 14'd0};
      default: len_add = {in_byte[6:0], 21'd0};
    endcase
  end

  // Whole packet size: header byte, length bytes and body
  assign total_bytes = {1'b0, rl_next} + {{(MAXB_W-CNT_W){1'b0}}, cnt_next}
                       + MAXB_W'(1);

  // Tag body bytes by their offset
  assign topic_end = {{(LEN_W-TOPIC_W){1'b0}}, topic_len} + LEN_W'(2);
  assign id_end    = {{(LEN_W-TOPIC_W){1'b0}}, topic_len} + LEN_W'(4);

  always_comb begin
    body_kind = mqttrx_pkg::KIND_OTHER;
    if (header_byte[7:4] == mqttrx_pkg::PKT_PUBLISH) begin
      if (body_count < LEN_W'(2)) begin
        body_kind = mqttrx_pkg::KIND_TOPIC_LEN;
      end else if (body_count < topic_end) begin
        body_kind = mqttrx_pkg::KIND_TOPIC;
      end else if (header_byte[2:1] != 2'd0 && body_count < id_end) begin
        body_kind = mqttrx_pkg::KIND_PACKET_ID;
      end else begin
        body_kind = mqttrx_pkg::KIND_PAYLOAD;
      end
    end else if ((header_byte[7:4] == mqttrx_pkg::PKT_PUBACK ||
                  header_byte[7:4] == mqttrx_pkg::PKT_SUBACK ||
                  header_byte[7:4] == mqttrx_pkg::PKT_UNSUBACK) &&
                 body_count < LEN_W'(2)) begin
      body_kind = mqttrx_pkg::KIND_PACKET_ID;
    end
  end

  // Phase walk: header byte, length digits, body
  always_comb begin
    phase_next  = phase;
    header_next = header_byte;
    rl_next     = remaining_len;
    cnt_next    = len_count;
    body_next   = body_count;
    tl_next     = topic_len;
    rc_next     = return_code;
    ovs_next    = oversize;
    res_kind    = mqttrx_pkg::KIND_HEADER;
    do_finish   = 1'b0;
    malformed   = 1'b0;
    unique case (phase)
      PH_LENGTH: begin
        res_kind = mqttrx_pkg::KIND_LENGTH;
        if (len_count >= CNT_W'(4)) begin
          // four continuation bits in a row: drop the packet as malformed
          malformed  = 1'b1;
          phase_next = PH_HEADER;
        end else begin
          rl_next  = remaining_len | len_add;
          cnt_next = len_count + CNT_W'(1);
          if (!in_byte[7]) begin
            ovs_next = total_bytes > max_bytes;
            if (rl_next == '0) begin
              do_finish = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        res_kind = body_kind;
        if (body_count == LEN_W'(0)) begin
          tl_next = {8'd0, in_byte};
        end else if (body_count == LEN_W'(1)) begin
          tl_next = {topic_len[7:0], in_byte};
          rc_next = in_byte;
        end
        body_next = body_count + LEN_W'(1);
        if (body_next >= remaining_len) begin
          do_finish = 1'b1;
        end
      end
      default: begin
        header_next = in_byte;
        rl_next     = '0;
        cnt_next    = '0;
        body_next   = '0;
        tl_next     = '0;
        rc_next     = '0;
        ovs_next    = 1'b0;
        phase_next  = PH_LENGTH;
      end
    endcase
    if (do_finish) begin
      phase_next = PH_HEADER;
    end
  end

  assign fin.pkt_type    = header_next[7:4];
  assign fin.qos         = header_next[2:1];
  assign fin.rem_len     = rl_next;
  assign fin.topic_len   = tl_next;
  assign fin.return_code = rc_next;
  assign fin.oversize    = ovs_next;

  mqttrx_verdict u_verdict (
    .fin (fin),
    .eff (eff)
  );

  assign res_qos = (header_next[7:4] == mqttrx_pkg::PKT_PUBLISH) ? header_next[2:1] : 2'd0;

  // Effects appear only on the closing byte
  always_comb begin
    res_end      = do_finish || malformed;
    res_verdict  = mqttrx_pkg::VERDICT_OK;
    res_update   = mqttrx_pkg::UPD_NONE;
    res_ping     = 1'b0;
    res_activity = 1'b0;
    if (malformed) begin
      res_verdict = mqttrx_pkg::VERDICT_MALFORMED;
    end else if (do_finish) begin
      res_verdict  = eff.verdict;
      res_update   = eff.update;
      res_ping     = eff.ping_clear;
      res_activity = eff.activity;
    end
  end

  // State, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAXB_W'(1024);
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_HEADER;
    end else begin
      if (cfg_wen) begin
        max_bytes <= cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        phase     <= phase_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    // payload: no reset needed
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
    if (advance) begin
      header_byte   <= header_next;
      remaining_len <= rl_next;
      len_count     <= cnt_next;
      body_count    <= body_next;
      topic_len     <= tl_next;
      return_code   <= rc_next;
      oversize      <= ovs_next;
      out_kind      <= res_kind;
      out_byte      <= in_byte;
      out_end       <= res_end;
      out_pkt       <= header_next[7:4];
      out_qos       <= res_qos;
      out_verdict   <= res_verdict;
      out_update    <= res_update;
      out_ping      <= res_ping;
      out_activity  <= res_activity;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_end;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {3'b000, out_activity, out_ping, out_update, out_verdict,
                          out_qos, out_pkt, out_byte};

`ifndef SYNTHESIS
  // A body in progress always has bytes left to count
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (remaining_len != '0 && body_count < remaining_len))
    else $error("body phase with no bytes left");

  // A header byte never closes a packet
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_kind == mqttrx_pkg::KIND_HEADER) |-> !m_axis_tlast)
    else $error("header byte tagged as packet end");

  // Going connected always comes with an ok verdict and fresh activity
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_update == mqttrx_pkg::UPD_CONNECT) |->
      (m_axis_tlast && out_activity && out_verdict == mqttrx_pkg::VERDICT_OK))
    else $error("connect effect without ok verdict");

  // Length digit counter stops at the malformed limit
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LENGTH) |-> (len_count <= CNT_W'(4)))
    else $error("length byte counter overran");
`endif

endmodule

`default_nettype wire

// File: verif/tb_mqtt_receive_packet_parser_top.sv
// Self-checking testbench of the MQTT receive packet parser top level.
`timescale 1ns / 1ps

typedef enum logic [2:0] {
  PH_HEADER,
  PH_LENGTH,
  PH_BODY
} parse_phase_t;

// Expected tagged byte, one per received byte
typedef struct packed {
  mqttrx_pkg::byte_kind_t    kind;
  logic [7:0]                data;
  logic                      last;
  logic [3:0]                ptype;
  logic [1:0]                qos;
  mqttrx_pkg::verdict_t      verdict;
  mqttrx_pkg::state_update_t update;
  logic                      ping;
  logic                      act;
} tagged_byte_t;

// Tracks the parse of the received stream and checks the tagged output against it
class mqtt_parse_tracker;
  parse_phase_t phase;
  logic [7:0]   hdr;
  logic [31:0]  rem_len;
  logic [2:0]   len_cnt;
  logic [31:0]  body_cnt;
  logic [15:0]  topic_len;
  logic [7:0]   ret_code;
  logic         oversize;
  logic [28:0]  max_bytes;
  tagged_byte_t tagged_due[$];
  int           errors;
  int           outputs;

  function new();
    phase     = PH_HEADER;
    hdr       = '0;
    rem_len   = '0;
    len_cnt   = '0;
    body_cnt  = '0;
    topic_len = '0;
    ret_code  = '0;
    oversize  = 1'b0;
    max_bytes = 29'd1024;
    errors    = 0;
    outputs   = 0;
  endfunction

  function logic [3:0] ptype();
    return hdr[7:4];
  endfunction

  function logic [1:0] pqos();
    return (hdr[7:4] == mqttrx_pkg::PKT_PUBLISH) ? hdr[2:1] : 2'd0;
  endfunction

  function mqttrx_pkg::byte_kind_t body_tag(logic [31:0] idx);
    if (ptype() == mqttrx_pkg::PKT_PUBLISH) begin
      if (idx < 2) return mqttrx_pkg::KIND_TOPIC_LEN;
      if (idx < 2 + topic_len) return mqttrx_pkg::KIND_TOPIC;
      if (pqos() != 2'd0 && idx < 4 + topic_len) return mqttrx_pkg::KIND_PACKET_ID;
      return mqttrx_pkg::KIND_PAYLOAD;
    end
    if ((ptype() == mqttrx_pkg::PKT_PUBACK || ptype() == mqttrx_pkg::PKT_SUBACK ||
         ptype() == mqttrx_pkg::PKT_UNSUBACK) && idx < 2)
      return mqttrx_pkg::KIND_PACKET_ID;
    return mqttrx_pkg::KIND_OTHER;
  endfunction

  // Verdict and client effects on the last byte of a packet
  function tagged_byte_t close_packet(tagged_byte_t t);
    t.last = 1'b1;
    if (oversize) begin
      t.verdict = mqttrx_pkg::VERDICT_OVERSIZE;
    end else begin
      case (ptype())
        mqttrx_pkg::PKT_CONNACK: begin
          if (rem_len < 2) begin
            t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else if (ret_code == 8'h00) begin
            t.update = mqttrx_pkg::UPD_CONNECT;
            t.act    = 1'b1;
          end else begin
            t.verdict = mqttrx_pkg::VERDICT_REFUSED;
            t.update  = mqttrx_pkg::UPD_IDLE;
          end
        end
        mqttrx_pkg::PKT_PUBLISH: begin
          if (rem_len < 2) t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          else if (topic_len == 16'd0) t.verdict = mqttrx_pkg::VERDICT_EMPTY_TOPIC;
          else if (2 + topic_len > rem_len) t.verdict = mqttrx_pkg::VERDICT_TOPIC_OVERRUN;
          else if (pqos() != 2'd0 && 4 + topic_len > rem_len)
            t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
        end
        mqttrx_pkg::PKT_PUBACK: begin
          if (rem_len < 2) begin
            t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            t.update = mqttrx_pkg::UPD_CONNECT;
            t.act    = 1'b1;
          end
        end
        mqttrx_pkg::PKT_SUBACK: begin
          if (rem_len < 3) begin
            t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            t.update = mqttrx_pkg::UPD_CONNECT;
            t.act    = 1'b1;
          end
        end
        mqttrx_pkg::PKT_UNSUBACK: begin
          t.verdict = mqttrx_pkg::VERDICT_OK;
        end
        mqttrx_pkg::PKT_PINGRESP: begin
          if (rem_len != 0) begin
            t.verdict = mqttrx_pkg::VERDICT_BAD_LENGTH;
          end else begin
            t.ping = 1'b1;
            t.act  = 1'b1;
          end
        end
        default: begin
          t.verdict = mqttrx_pkg::VERDICT_UNSUPPORTED;
        end
      endcase
    end
    phase = PH_HEADER;
    return t;
  endfunction

  function void note_rx_byte(logic [7:0] b);
    tagged_byte_t t;
    logic [31:0]  total;
    t      = '0;
    t.data = b;
    case (phase)
      PH_LENGTH: begin
        t.kind = mqttrx_pkg::KIND_LENGTH;
        if (len_cnt >= 4) begin
          t.last    = 1'b1;
          t.verdict = mqttrx_pkg::VERDICT_MALFORMED;
          phase     = PH_HEADER;
        end else begin
          rem_len = rem_len | ({25'd0, b[6:0]} << (7 * len_cnt));
          len_cnt = len_cnt + 3'd1;
          if (!b[7]) begin
            total    = 1 + len_cnt + rem_len;
            oversize = total > {3'd0, max_bytes};
            if (rem_len == 0) t = close_packet(t);
            else phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        t.kind = body_tag(body_cnt);
        if (body_cnt == 0) begin
          topic_len = {8'd0, b};
        end else if (body_cnt == 1) begin
          topic_len = {topic_len[7:0], b};
          ret_code  = b;
        end
        body_cnt = (body_cnt + 1) & 32'h0FFF_FFFF;
        if (body_cnt >= rem_len) t = close_packet(t);
      end
      default: begin
        hdr       = b;
        rem_len   = '0;
        len_cnt   = '0;
        body_cnt  = '0;
        topic_len = '0;
        ret_code  = '0;
        oversize  = 1'b0;
        phase     = PH_LENGTH;
        t.kind    = mqttrx_pkg::KIND_HEADER;
      end
    endcase
    t.ptype = ptype();
    t.qos   = pqos();
    tagged_due.push_back(t);
  endfunction

  function void report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endfunction

  function void check_tagged_byte(logic [23:0] d, logic last, logic [2:0] kind);
    tagged_byte_t e;
    string        bad;
    outputs++;
    if (tagged_due.size() == 0) begin
      report_mismatch($sformatf("output %0d with nothing expected: tdata=%h last=%b kind=%0d",
                                outputs, d, last, kind));
      return;
    end
    e   = tagged_due.pop_front();
    bad = "";
    if (kind !== e.kind)         bad = {bad, " byte_kind"};
    if (d[7:0] !== e.data)       bad = {bad, " data_byte"};
    if (last !== e.last)         bad = {bad, " packet_end"};
    if (d[11:8] !== e.ptype)     bad = {bad, " packet_kind"};
    if (d[13:12] !== e.qos)      bad = {bad, " publish_qos"};
    if (d[16:14] !== e.verdict)  bad = {bad, " verdict"};
    if (d[18:17] !== e.update)   bad = {bad, " state_update"};
    if (d[19] !== e.ping)        bad = {bad, " ping_clear"};
    if (d[20] !== e.act)         bad = {bad, " activity"};
    if (d[23:21] !== 3'd0)       bad = {bad, " pad"};
    if (bad != "")
      report_mismatch($sformatf("output %0d:%s got tdata=%h last=%b kind=%0d want %h/%b/%0d",
        outputs, bad, d, last, kind,
        {3'd0, e.act, e.ping, e.update, e.verdict, e.qos, e.ptype, e.data}, e.last, e.kind));
  endfunction
endclass

module tb_mqtt_receive_packet_parser_top;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wen       = 1'b0;
  logic [28:0] cfg_wdata     = 29'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  mqtt_parse_tracker tracker = new();

  // Input gap chance per byte in percent; calm turns off idling on both sides
  int unsigned gap_pct = 20;
  bit          calm    = 1'b0;
  int          sent    = 0;

  mqtt_receive_packet_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Sample both streams at the edge: predict on every accepted byte first,
  // then check every accepted tagged byte against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_rx_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_tagged_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // Stall the output side in random bursts; hold ready high once calm
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(2) != 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Offer one byte, maybe after an idle burst, and hold it until accepted.
  // Valid stays high between back-to-back bytes.
  task automatic push_byte(input logic [7:0] b);
    if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Drop valid, let the sampler take the last accepted byte, wait for every
  // tagged byte to come out, then let the two-stage pipe empty completely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.tagged_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write max_packet_bytes while the parser is idle
  task automatic set_max_bytes(input logic [28:0] v);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    tracker.max_bytes = v;
  endtask

  // Build one whole packet with random content. Mostly well formed; now and
  // then a broken length for the type, a bad topic, odd flags, a padded or
  // non-minimal length encoding, or a malformed five-byte length.
  task automatic send_packet();
    logic [7:0]  body[$];
    logic [7:0]  hdr;
    logic [3:0]  ty;
    logic [15:0] tl;
    int          pick;
    int          n;
    int          rl;
    int          mindig;
    int          ndig;
    gap_pct = ($urandom_range(3) == 0) ? 0 : 20;
    pick    = $urandom_range(99);
    if (pick < 15) ty = mqttrx_pkg::PKT_CONNACK;
    else if (pick < 50) ty = mqttrx_pkg::PKT_PUBLISH;
    else if (pick < 60) ty = mqttrx_pkg::PKT_PUBACK;
    else if (pick < 70) ty = mqttrx_pkg::PKT_SUBACK;
    else if (pick < 78) ty = mqttrx_pkg::PKT_UNSUBACK;
    else if (pick < 88) ty = mqttrx_pkg::PKT_PINGRESP;
    else ty = 4'($urandom_range(15));
    hdr = {ty, 4'h0};
    if (ty == mqttrx_pkg::PKT_PUBLISH || $urandom_range(7) == 0)
      hdr[3:0] = 4'($urandom_range(15));

    // Malformed: four length bytes all with the continuation bit, then any byte
    if ($urandom_range(24) == 0) begin
      push_byte(hdr);
      repeat (4) push_byte(8'h80 | 8'($urandom_range(127)));
      push_byte(8'($urandom_range(255)));
      return;
    end

    case (ty)
      mqttrx_pkg::PKT_CONNACK: begin
        body.push_back(8'($urandom_range(1)));
        body.push_back(($urandom_range(9) < 7) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      mqttrx_pkg::PKT_PUBLISH: begin
        n  = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6);
        tl = ($urandom_range(19) == 0) ? 16'($urandom) : 16'(n);
        body.push_back(tl[15:8]);
        body.push_back(tl[7:0]);
        repeat (n) body.push_back(8'($urandom_range(255)));
        if (hdr[2:1] != 2'd0) repeat (2) body.push_back(8'($urandom_range(255)));
        // A few long payloads push the length into a second digit
        n = ($urandom_range(24) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 8);
        repeat (n) body.push_back(8'($urandom_range(255)));
      end
      mqttrx_pkg::PKT_PUBACK, mqttrx_pkg::PKT_UNSUBACK: begin
        repeat (2) body.push_back(8'($urandom_range(255)));
      end
      mqttrx_pkg::PKT_SUBACK: begin
        repeat ($urandom_range(3, 6)) body.push_back(8'($urandom_range(255)));
      end
      mqttrx_pkg::PKT_PINGRESP: begin
      end
      default: begin
        repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(255)));
      end
    endcase

    // Break the length rule now and then: cut the body short or pad it
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(0, body.size() + 2);
      while (body.size() > n) void'(body.pop_back());
      while (body.size() < n) body.push_back(8'($urandom_range(255)));
    end

    rl     = body.size();
    mindig = (rl < 128) ? 1 : 2;
    ndig   = ($urandom_range(6) == 0) ? $urandom_range(mindig, 4) : mindig;
    push_byte(hdr);
    for (int i = 0; i < ndig; i++)
      push_byte({(i < ndig - 1), 7'((rl >> (7 * i)) & 127)});
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic run_packets(input int budget);
    int start;
    start = sent;
    while (sent - start < budget) send_packet();
  endtask

  initial begin
    // Zero-length PINGRESP, good and refused CONNACK, malformed length with
    // all-ones bytes, and a QoS 3 PUBLISH with topic, packet id and no payload.
    logic [7:0] opening[$];
    opening = '{8'hD0, 8'h00,
                8'h20, 8'h02, 8'h00, 8'h00,
                8'h20, 8'h02, 8'h01, 8'h05,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h36, 8'h05, 8'h00, 8'h01, 8'h41, 8'h00, 8'h07};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes under the reset limit
    foreach (opening[i]) push_byte(opening[i]);
    run_packets(80);

    // Smallest limit: only zero-length packets fit
    set_max_bytes(29'd2);
    run_packets(90);
    // Largest limit
    set_max_bytes(29'd268435460);
    run_packets(90);
    // Small limits put many packets right at or over the edge
    repeat (3) begin
      set_max_bytes(29'($urandom_range(3, 24)));
      run_packets(90);
    end
    set_max_bytes(29'd1024);
    run_packets(90);
    set_max_bytes(29'($urandom_range(25, 600)));
    run_packets(90);

    // Last stretch with no idling on either side
    set_max_bytes(29'($urandom_range(3, 40)));
    calm = 1'b1;
    run_packets(90);

    settle();
    if (tracker.errors == 0 && tracker.tagged_due.size() == 0) begin
      $display("** mqtt_receive_packet_parser_top: PASSED **");
    end else begin
      $display("** mqtt_receive_packet_parser_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("** mqtt_receive_packet_parser_top: FAILED **");
    $finish;
  end

endmodule
